// ===== hw/rtl/lfu_pkg.sv =====
package lfu_pkg;

    // A page number is one byte, so the page space is the full 256 pages and
    // the reduction of a page number into that space is the identity.
    localparam int LFU_PAGE_W     = 8;
    localparam int LFU_PAGE_SPACE = 256;

    // Frame count register.
    localparam int              LFU_CFG_W           = 4;
    localparam logic [LFU_CFG_W-1:0] LFU_FRAME_COUNT_RST = 4'd3;

    // Running fault total.
    localparam int LFU_FAULT_W = 32;

    // Command broadcast from the sequencer to every frame cell.
    typedef struct packed {
        logic                  upd;   // count update for the referenced page
        logic                  scan;  // advance the minimum search one cell
        logic [LFU_PAGE_W-1:0] page;  // page of the request in flight
    } t_cell_cmd;

endpackage

// ===== hw/rtl/lfu_count_mem.sv =====
module lfu_count_mem
    import lfu_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_re,
    input  logic [LFU_PAGE_W-1:0] i_raddr,
    output logic [COUNT_BITS-1:0] o_rdata,
    input  logic                  i_we,
    input  logic [LFU_PAGE_W-1:0] i_waddr,
    input  logic [COUNT_BITS-1:0] i_wdata
);

    // Use counts, one entry per page. An entry never written since reset
    // reads as zero through its valid bit.
    logic [COUNT_BITS-1:0]     r_mem [LFU_PAGE_SPACE];
    logic [LFU_PAGE_SPACE-1:0] r_vld;
    logic [COUNT_BITS-1:0]     r_q;
    logic                      r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_q_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_q_vld ? r_q : '0;

endmodule

// ===== hw/rtl/lfu_frame_cell.sv =====
module lfu_frame_cell
    import lfu_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int FIW        = 3,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_cmd             i_cmd,
    input  logic                  i_load,
    input  logic [COUNT_BITS-1:0] i_cnt,
    output logic                  o_match,
    input  logic                  i_tok_found,
    input  logic [COUNT_BITS-1:0] i_tok_cnt,
    input  logic [LFU_PAGE_W-1:0] i_tok_page,
    input  logic [FIW-1:0]        i_tok_idx,
    output logic                  o_tok_found,
    output logic [COUNT_BITS-1:0] o_tok_cnt,
    output logic [LFU_PAGE_W-1:0] o_tok_page,
    output logic [FIW-1:0]        o_tok_idx
);

    logic                  r_occ;
    logic [LFU_PAGE_W-1:0] r_page;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_tok_found;
    logic [COUNT_BITS-1:0] r_tok_cnt;
    logic [LFU_PAGE_W-1:0] r_tok_page;
    logic [FIW-1:0]        r_tok_idx;
    logic                  w_take;

    assign o_match = r_occ && (r_page == i_cmd.page);

    // Strictly lower count wins, so an earlier frame keeps a tie.
    assign w_take = r_occ && (!i_tok_found || (r_cnt < i_tok_cnt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= 1'b0;
            r_tok_found <= 1'b0;
        end else begin
            if (i_load) begin
                r_occ <= 1'b1;
            end
            if (i_cmd.scan) begin
                r_tok_found <= w_take || i_tok_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_page <= i_cmd.page;
            r_cnt  <= i_cnt;
        end else if (i_cmd.upd && o_match) begin
            r_cnt <= i_cnt;
        end
        if (i_cmd.scan) begin
            if (w_take) begin
                r_tok_cnt  <= r_cnt;
                r_tok_page <= r_page;
                r_tok_idx  <= FIW'(IDX);
            end else begin
                r_tok_cnt  <= i_tok_cnt;
                r_tok_page <= i_tok_page;
                r_tok_idx  <= i_tok_idx;
            end
        end
    end

    assign o_tok_found = r_tok_found;
    assign o_tok_cnt   = r_tok_cnt;
    assign o_tok_page  = r_tok_page;
    assign o_tok_idx   = r_tok_idx;

endmodule

// ===== hw/rtl/lfu_page_replacement_top.sv =====
// LFU page replacement engine. Each request carries one page number. The
// block raises that page's use count (saturating at 2^COUNT_BITS - 1), looks
// the page up in the resident frames, and on a miss counts a fault and
// either fills the next empty frame or replaces the resident page with the
// lowest use count, the lowest frame index winning ties. Use counts are kept
// per page for the whole page space and survive eviction; they read as zero
// after reset, which is synchronous, and the block is ready once reset is
// released. A request is taken on a rising edge with i_start high and o_busy
// low. Its result appears on the o_ ports for exactly one cycle, marked by
// o_valid; the receiver cannot stall it, so it must take the result in that
// cycle. A hit or a fill into an empty frame runs one minimum search, and
// o_valid rises in the same cycle that o_busy falls; an eviction needs a
// second minimum search. The lowest-count search travels one cell per cycle
// down the row of frame cells. The frame limit register may be written only
// while o_busy is low; zero acts as one frame, and values above MAX_FRAMES
// act as MAX_FRAMES.
module lfu_page_replacement_top
    import lfu_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [LFU_PAGE_W-1:0]  i_page,
    input  logic                   i_cfg_we,
    input  logic [LFU_CFG_W-1:0]   i_cfg_data,
    output logic                   o_valid,
    output logic                   o_hit,
    output logic                   o_evicted_valid,
    output logic [LFU_PAGE_W-1:0]  o_evicted_page,
    output logic [LFU_PAGE_W-1:0]  o_next_victim,
    output logic [LFU_FAULT_W-1:0] o_fault_total
);

    // Width of a frame index, and of the occupancy count that can also hold
    // MAX_FRAMES itself.
    localparam int FIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FUW = $clog2(MAX_FRAMES + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_PICK = 4'b1000
    } t_state;

    t_state                 r_state;
    logic [LFU_CFG_W-1:0]   r_frame_count;
    logic [LFU_PAGE_W-1:0]  r_page;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic                   r_hit;
    logic                   r_evict;
    logic                   r_ev_valid;
    logic [LFU_PAGE_W-1:0]  r_ev_page;
    logic [FIW-1:0]         r_step;
    logic [FUW-1:0]         r_frames_used;
    logic [LFU_FAULT_W-1:0] r_fault;

    logic                   r_o_valid;
    logic                   r_o_hit;
    logic                   r_o_ev_valid;
    logic [LFU_PAGE_W-1:0]  r_o_ev_page;
    logic [LFU_PAGE_W-1:0]  r_o_victim;
    logic [LFU_FAULT_W-1:0] r_o_fault;

    logic                   w_accept;
    logic                   w_in_read;
    logic                   w_in_pick;
    logic [COUNT_BITS-1:0]  w_rdata;
    logic [COUNT_BITS-1:0]  w_new_cnt;
    logic [COUNT_BITS-1:0]  w_load_cnt;
    logic [FUW-1:0]         w_limit;
    logic                   w_hit;
    logic                   w_fill;
    logic                   w_scan_last;
    t_cell_cmd              w_cmd;

    logic [MAX_FRAMES-1:0]  w_match;
    logic [MAX_FRAMES-1:0]  w_load;
    logic                   w_tok_found [MAX_FRAMES];
    logic [COUNT_BITS-1:0]  w_tok_cnt   [MAX_FRAMES];
    logic [LFU_PAGE_W-1:0]  w_tok_page  [MAX_FRAMES];
    logic [FIW-1:0]         w_tok_idx   [MAX_FRAMES];

    assign w_accept  = i_start && (r_state == S_IDLE);
    assign w_in_read = (r_state == S_READ);
    assign w_in_pick = (r_state == S_PICK);

    // The count memory is read at the accepting edge and written back with
    // the incremented count in the following cycle.
    lfu_count_mem #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (w_accept),
        .i_raddr (i_page),
        .o_rdata (w_rdata),
        .i_we    (w_in_read),
        .i_waddr (r_page),
        .i_wdata (w_new_cnt)
    );

    assign w_new_cnt = (w_rdata == '1) ? w_rdata : w_rdata + 1'b1;

    // Effective number of frames: zero behaves as one, and the register is
    // clipped to the number of frame cells that exist.
    always_comb begin
        if (r_frame_count == '0) begin
            w_limit = FUW'(1);
        end else if (int'(r_frame_count) > MAX_FRAMES) begin
            w_limit = FUW'(MAX_FRAMES);
        end else begin
            w_limit = FUW'(r_frame_count);
        end
    end

    // Every occupied cell compares its page in parallel; the cells still
    // hold their old contents during the read cycle.
    assign w_hit  = |w_match;
    assign w_fill = w_in_read && !w_hit && (r_frames_used < w_limit);

    assign w_cmd.upd  = w_in_read;
    assign w_cmd.scan = (r_state == S_SCAN);
    assign w_cmd.page = r_page;

    assign w_load_cnt  = w_in_read ? w_new_cnt : r_cnt;
    assign w_scan_last = (r_step == FIW'(MAX_FRAMES - 1));

    // Row of frame cells. The lowest-count token enters at cell 0 and moves
    // one cell per scan cycle, so the last cell holds the answer once the scan
    // has passed every cell.
    for (genvar gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
        logic                  w_in_found;
        logic [COUNT_BITS-1:0] w_in_cnt;
        logic [LFU_PAGE_W-1:0] w_in_page;
        logic [FIW-1:0]        w_in_idx;

        if (gi == 0) begin : g_head
            assign w_in_found = 1'b0;
            assign w_in_cnt   = '0;
            assign w_in_page  = '0;
            assign w_in_idx   = '0;
        end else begin : g_link
            assign w_in_found = w_tok_found[gi-1];
            assign w_in_cnt   = w_tok_cnt[gi-1];
            assign w_in_page  = w_tok_page[gi-1];
            assign w_in_idx   = w_tok_idx[gi-1];
        end

        // A cell is loaded either as the next empty frame on a fill, or as
        // the chosen victim frame on an eviction.
        assign w_load[gi] = (w_fill && (r_frames_used == FUW'(gi)))
                         || (w_in_pick && r_evict
                             && (w_tok_idx[MAX_FRAMES-1] == FIW'(gi)));

        lfu_frame_cell #(
            .COUNT_BITS (COUNT_BITS),
            .FIW        (FIW),
            .IDX        (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_load      (w_load[gi]),
            .i_cnt       (w_load_cnt),
            .o_match     (w_match[gi]),
            .i_tok_found (w_in_found),
            .i_tok_cnt   (w_in_cnt),
            .i_tok_page  (w_in_page),
            .i_tok_idx   (w_in_idx),
            .o_tok_found (w_tok_found[gi]),
            .o_tok_cnt   (w_tok_cnt[gi]),
            .o_tok_page  (w_tok_page[gi]),
            .o_tok_idx   (w_tok_idx[gi])
        );
    end

    // Sequencer. READ updates the count and decides hit, fill or eviction;
    // SCAN runs the minimum search; PICK either performs the eviction and
    // searches again for the next victim, or delivers the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_count <= LFU_FRAME_COUNT_RST;
            r_frames_used <= '0;
            r_fault       <= '0;
            r_evict       <= 1'b0;
            r_step        <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (!w_hit) begin
                        if (r_fault != '1) begin
                            r_fault <= r_fault + 1'b1;
                        end
                        if (w_fill) begin
                            r_frames_used <= r_frames_used + 1'b1;
                        end else begin
                            r_evict <= 1'b1;
                        end
                    end
                    r_step  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_step <= r_step + 1'b1;
                    if (w_scan_last) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (r_evict) begin
                        r_evict <= 1'b0;
                        r_step  <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request payload and result registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page     <= i_page;
            r_ev_valid <= 1'b0;
            r_ev_page  <= '0;
        end
        if (w_in_read) begin
            r_hit <= w_hit;
            r_cnt <= w_new_cnt;
        end
        if (w_in_pick && r_evict) begin
            r_ev_valid <= 1'b1;
            r_ev_page  <= w_tok_page[MAX_FRAMES-1];
        end
        if (w_in_pick && !r_evict) begin
            r_o_hit      <= r_hit;
            r_o_ev_valid <= r_ev_valid;
            r_o_ev_page  <= r_ev_page;
            r_o_victim   <= w_tok_found[MAX_FRAMES-1] ? w_tok_page[MAX_FRAMES-1] : '0;
            r_o_fault    <= r_fault;
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_hit           = r_o_hit;
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_page  = r_o_ev_page;
    assign o_next_victim   = r_o_victim;
    assign o_fault_total   = r_o_fault;

    // A result is delivered only once the sequencer is back to idle.
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobed while a request is still in flight");

    // A reference is never both a hit and an eviction.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted_valid))
        else $error("hit reported together with an eviction");

    // Occupancy never exceeds the number of frame cells.
    a_frames_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_frames_used) <= MAX_FRAMES)
        else $error("frame occupancy beyond the cell row");

    // An eviction is only ever scheduled when no empty frame may be filled.
    a_evict_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_read && !w_hit && !w_fill) |-> (r_frames_used >= w_limit))
        else $error("eviction chosen while a frame is still free");

    // The fault total never decreases outside reset.
    a_fault_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fault >= $past(r_fault)))
        else $error("fault total decreased");

endmodule

// ===== tb/lfu_page_replacement_checker.sv =====
module lfu_page_replacement_checker
    import lfu_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [LFU_PAGE_W-1:0]  i_page,
    input  logic                   i_cfg_we,
    input  logic [LFU_CFG_W-1:0]   i_cfg_data,
    input  logic                   i_valid,
    input  logic                   i_hit,
    input  logic                   i_evicted_valid,
    input  logic [LFU_PAGE_W-1:0]  i_evicted_page,
    input  logic [LFU_PAGE_W-1:0]  i_next_victim,
    input  logic [LFU_FAULT_W-1:0] i_fault_total,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_result_count,
    output int                     o_hit_count,
    output int                     o_evict_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                   hit;
        logic                   evicted_valid;
        logic [LFU_PAGE_W-1:0]  evicted_page;
        logic [LFU_PAGE_W-1:0]  next_victim;
        logic [LFU_FAULT_W-1:0] fault_total;
    } t_lfu_outcome;

    logic [COUNT_BITS-1:0]  page_uses [LFU_PAGE_SPACE];
    logic [LFU_PAGE_W-1:0]  frame_pages [MAX_FRAMES];
    int unsigned            frames_held;
    logic [LFU_FAULT_W-1:0] faults;
    logic [LFU_CFG_W-1:0]   frame_limit_reg;
    t_lfu_outcome           awaited_outcomes [$];

    function automatic int unsigned effective_limit();
        if (frame_limit_reg == '0) return 1;
        if (frame_limit_reg > MAX_FRAMES) return MAX_FRAMES;
        return int'(frame_limit_reg);
    endfunction

    // Occupied frame with the lowest use count; the first one wins a tie.
    function automatic int unsigned least_used_frame();
        int unsigned best = 0;
        for (int unsigned i = 1; i < frames_held; i++) begin
            if (page_uses[frame_pages[i]] < page_uses[frame_pages[best]]) best = i;
        end
        return best;
    endfunction

    function automatic t_lfu_outcome apply_reference(logic [LFU_PAGE_W-1:0] page);
        t_lfu_outcome outcome;
        logic         resident;
        int unsigned  slot;
        outcome  = '0;
        resident = 1'b0;
        if (page_uses[page] != '1) page_uses[page] = page_uses[page] + 1'b1;
        for (int unsigned i = 0; i < frames_held; i++) begin
            if (frame_pages[i] == page) resident = 1'b1;
        end
        if (!resident) begin
            if (faults != '1) faults = faults + 1'b1;
            if (frames_held < effective_limit()) begin
                frame_pages[frames_held] = page;
                frames_held++;
            end else begin
                slot                  = least_used_frame();
                outcome.evicted_valid = 1'b1;
                outcome.evicted_page  = frame_pages[slot];
                frame_pages[slot]     = page;
            end
        end
        outcome.hit = resident;
        if (frames_held > 0) outcome.next_victim = frame_pages[least_used_frame()];
        outcome.fault_total = faults;
        return outcome;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_lfu_outcome want;
        if (!i_rst_n) begin
            foreach (page_uses[i]) page_uses[i] = '0;
            frames_held     = 0;
            faults          = '0;
            frame_limit_reg = LFU_FRAME_COUNT_RST;
            awaited_outcomes.delete();
            o_fail_count    = 0;
            o_result_count  = 0;
            o_hit_count     = 0;
            o_evict_count   = 0;
        end else begin
            // The result of an earlier request is retired before a request taken
            // on the same edge is predicted.
            if (i_valid) begin
                o_result_count++;
                if (i_hit) o_hit_count++;
                if (i_evicted_valid) o_evict_count++;
                if (awaited_outcomes.size() == 0) begin
                    $error("Result with no request outstanding.");
                    o_fail_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("hit", want.hit, i_hit);
                    check_field("evicted_valid", want.evicted_valid, i_evicted_valid);
                    check_field("evicted_page", want.evicted_page, i_evicted_page);
                    check_field("next_victim", want.next_victim, i_next_victim);
                    check_field("fault_total", want.fault_total, i_fault_total);
                end
            end
            if (i_cfg_we) frame_limit_reg = i_cfg_data;
            if (i_start && !i_busy) begin
                awaited_outcomes = {awaited_outcomes, apply_reference(i_page)};
            end
        end
        o_pending = awaited_outcomes.size();
    end

endmodule

// ===== tb/lfu_page_replacement_top_tb.sv =====
module lfu_page_replacement_top_tb
    import lfu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAMES = 8;
    localparam int COUNT_BITS = 16;

    // Frame limit settings. Zero must behave as a single frame and anything
    // above MAX_FRAMES must behave as MAX_FRAMES.
    localparam logic [LFU_CFG_W-1:0] FRAMES_AS_ONE    = '0;
    localparam logic [LFU_CFG_W-1:0] FRAMES_SINGLE    = 4'd1;
    localparam logic [LFU_CFG_W-1:0] FRAMES_PAIR      = 4'd2;
    localparam logic [LFU_CFG_W-1:0] FRAMES_ALL       = LFU_CFG_W'(MAX_FRAMES);
    localparam logic [LFU_CFG_W-1:0] FRAMES_ABOVE_MAX = '1;

    // References to one hot page, enough to pull its count well ahead.
    localparam int HOT_REPEATS   = 12;
    // Settling time after the drain, longer than an eviction takes from accept to result.
    localparam int SETTLE_CYCLES = 2 * MAX_FRAMES + 8;
    localparam int CHUNKS        = 4;
    localparam int CHUNK_ITEMS   = 67;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_start;
    logic                   o_busy;
    logic [LFU_PAGE_W-1:0]  i_page;
    logic                   i_cfg_we;
    logic [LFU_CFG_W-1:0]   i_cfg_data;
    logic                   o_valid;
    logic                   o_hit;
    logic                   o_evicted_valid;
    logic [LFU_PAGE_W-1:0]  o_evicted_page;
    logic [LFU_PAGE_W-1:0]  o_next_victim;
    logic [LFU_FAULT_W-1:0] o_fault_total;

    int          fail_count;
    int          pending;
    int          result_count;
    int          hit_count;
    int          evict_count;
    int unsigned sender_idle_pct;
    int unsigned limit_writes;

    lfu_page_replacement_top #(
        .MAX_FRAMES(MAX_FRAMES),
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_page         (i_page),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_page (o_evicted_page),
        .o_next_victim  (o_next_victim),
        .o_fault_total  (o_fault_total)
    );

    // The checker sits beside the block, predicts every accepted request and
    // compares each result strobe against the oldest prediction.
    lfu_page_replacement_checker #(
        .MAX_FRAMES(MAX_FRAMES),
        .COUNT_BITS(COUNT_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_page         (i_page),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (o_valid),
        .i_hit          (o_hit),
        .i_evicted_valid(o_evicted_valid),
        .i_evicted_page (o_evicted_page),
        .i_next_victim  (o_next_victim),
        .i_fault_total  (o_fault_total),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_hit_count    (hit_count),
        .o_evict_count  (evict_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net in case the block stops answering. The slowest correct run
    // takes well under one millisecond.
    initial begin
        #5ms;
        $display("lfu_page_replacement_top regression: fail");
        $finish;
    end

    // Keeps i_start low for a number of falling edges. The page lines carry
    // noise meanwhile, which the block has to ignore.
    task automatic hold_off(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            i_page  <= LFU_PAGE_W'($urandom);
        end
    endtask

    // Presents one request and returns at the rising edge that takes it.
    // i_start is left high, so back-to-back requests see a single assignment
    // per falling edge.
    task automatic request_page(input logic [LFU_PAGE_W-1:0] page);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
            hold_off($urandom_range(1, 3 * MAX_FRAMES));
        @(negedge i_clk);
        i_start <= 1'b1;
        i_page  <= page;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Stops sending and waits until every outstanding request has produced
    // its result. Since every request yields exactly one result, the block is
    // idle once nothing is pending.
    task automatic drain_requests();
        @(negedge i_clk);
        i_start <= 1'b0;
        wait (pending == 0);
    endtask

    // The frame limit may only change while the block is idle.
    task automatic write_frame_limit(input logic [LFU_CFG_W-1:0] value);
        drain_requests();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_writes++;
    endtask

    function automatic logic [LFU_CFG_W-1:0] pick_frame_limit();
        case ($urandom_range(5))
            0:       return FRAMES_AS_ONE;
            1:       return FRAMES_ABOVE_MAX;
            default: return LFU_CFG_W'($urandom_range(0, (1 << LFU_CFG_W) - 1));
        endcase
    endfunction

    // Most references come from a working set of two to MAX_FRAMES + 4 pages,
    // so that hits, fills and evictions all happen often; the rest are
    // arbitrary pages and the two extreme page numbers.
    task automatic run_random_chunk();
        logic [LFU_PAGE_W-1:0] base;
        int unsigned           span;
        int unsigned           roll;
        logic [LFU_PAGE_W-1:0] page;
        base = LFU_PAGE_W'($urandom);
        span = $urandom_range(2, MAX_FRAMES + 4);
        write_frame_limit(pick_frame_limit());
        repeat (CHUNK_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 75)
                page = base + LFU_PAGE_W'($urandom_range(0, span - 1));
            else if (roll < 90)
                page = LFU_PAGE_W'($urandom);
            else
                page = $urandom_range(1) ? '1 : '0;
            request_page(page);
            // Now and then the sender waits for every result before going on.
            if ($urandom_range(99) == 0) drain_requests();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_page          = '0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        sender_idle_pct = 0;
        limit_writes    = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening with the reset limit of three frames: fill from
        // empty, a hit, then two evictions where equal counts must pick the
        // lower frame, a third eviction, a second hit, and the extreme page numbers.
        request_page(8'h00);
        request_page(8'hFF);
        request_page(8'h00);
        request_page(8'h80);
        request_page(8'h01);
        request_page(8'hFF);
        request_page(8'h01);
        request_page(8'h01);

        // A zero limit acts as one frame while three are held: every miss
        // replaces among the held frames, and a repeated reference to the page
        // just brought in hits.
        write_frame_limit(FRAMES_AS_ONE);
        request_page(8'h07);
        request_page(8'h07);
        request_page(8'h00);
        request_page(8'h80);

        // A limit above the frame count saturates at MAX_FRAMES, so the
        // remaining frames fill before the next eviction.
        write_frame_limit(FRAMES_ABOVE_MAX);
        request_page(8'h55);
        request_page(8'hAA);
        request_page(8'h10);
        request_page(8'h11);
        request_page(8'h12);
        request_page(8'h13);
        request_page(8'h14);

        write_frame_limit(FRAMES_SINGLE);
        request_page(8'hC8);
        request_page(8'hC9);
        write_frame_limit(FRAMES_ALL);
        request_page(8'h55);
        request_page(8'hFE);

        // Random requests in three idling regimes: moderate sender gaps,
        // heavy gaps, and none at all.
        sender_idle_pct = 28;
        repeat (CHUNKS) run_random_chunk();
        sender_idle_pct = 50;
        repeat (CHUNKS) run_random_chunk();
        sender_idle_pct = 0;
        repeat (CHUNKS) run_random_chunk();

        // Hot page: one page is hit repeatedly with other pages resident,
        // so its count pulls far ahead. Misses afterwards must keep evicting
        // colder frames and leave the hot page alone.
        write_frame_limit(FRAMES_PAIR);
        request_page(8'h3C);
        request_page(8'hC3);
        repeat (HOT_REPEATS) request_page(8'hA5);
        request_page(8'h3C);
        request_page(8'h69);
        request_page(8'h96);
        request_page(8'hA5);

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d hits, %0d evictions, %0d limit writes,",
                 result_count, hit_count, evict_count, limit_writes);
        $display("including limits of zero, one, two, eight and fifteen and a hot page run.");
        if (fail_count == 0) begin
            $display("lfu_page_replacement_top regression: pass");
        end else begin
            $display("lfu_page_replacement_top regression: fail");
        end
        $finish;
    end

endmodule
